FILE: rtl/brre_pkg.sv
package brre_pkg;

  // default grid size
  localparam int WIDTH_DEF  = 64;
  localparam int HEIGHT_DEF = 8;

  // command and result field widths
  localparam int KIND_W  = 2;
  localparam int ARG_W   = 7;
  localparam int LIT_W   = 10;
  localparam int LIT_MAX = 1023;

  // command kinds; the fourth code leaves the grid alone
  typedef enum logic [KIND_W-1:0] {
    KIND_RECT = 2'd0,
    KIND_ROW  = 2'd1,
    KIND_COL  = 2'd2
  } kind_e;

  // one registered command
  typedef struct packed {
    kind_e            kind;
    logic [ARG_W-1:0] arg_a;
    logic [ARG_W-1:0] arg_b;
  } cmd_t;

  // status of a finished grid update
  typedef struct packed {
    logic valid;
    logic bad;
  } upd_t;

endpackage

FILE: rtl/bitmap_rect_rotate_engine_unit.sv
// order: a result strobe passes through each of the stages below in turn after its command is accepted
// throughput: one command per cycle, busy stays low and commands may arrive back to back
// stages: command register, grid update, per-row popcount, row sum into the result register
// reset: asynchronous, active low; the pixel grid clears to all dark
// results are shown for one cycle only, the receiver cannot stall
module bitmap_rect_rotate_engine_unit import brre_pkg::*; #(
  parameter int WIDTH  = WIDTH_DEF,
  parameter int HEIGHT = HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [ARG_W-1:0]  arg_a_i,
  input  logic [ARG_W-1:0]  arg_b_i,
  output logic              done_o,
  output logic [LIT_W-1:0]  lit_count_o,
  output logic              bad_index_o
);

  logic             cmd_valid_q;
  cmd_t             cmd_q;
  logic [WIDTH-1:0] rows [HEIGHT];
  upd_t             upd;

  // every stage moves on each cycle
  assign busy = 1'b0;

  // command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q.kind  <= kind_e'(kind_i);
      cmd_q.arg_a <= arg_a_i;
      cmd_q.arg_b <= arg_b_i;
    end
  end

  // pixel grid and its update logic
  brre_grid #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_grid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid_q),
    .cmd_i      (cmd_q),
    .rows_o     (rows),
    .upd_o      (upd)
  );

  // lit pixel count and result register
  brre_count #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_count (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rows_i     (rows),
    .upd_i      (upd),
    .done_o     (done_o),
    .lit_count_o(lit_count_o),
    .bad_index_o(bad_index_o)
  );

`ifndef SYNTHESIS
  // every result goes back to an accepted command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4))
    else $error("result without an accepted command");

  // the command register loads only on a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_q |-> $past(start) && !$past(busy))
    else $error("command register loaded without a transfer");
`endif

endmodule

FILE: rtl/brre_grid.sv
module brre_grid import brre_pkg::*; #(
  parameter int WIDTH  = WIDTH_DEF,
  parameter int HEIGHT = HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic [WIDTH-1:0] rows_o [HEIGHT],
  output upd_t             upd_o
);

  localparam int CW = $clog2(WIDTH);
  localparam int RW = $clog2(HEIGHT);

  logic [WIDTH-1:0]  rows_q [HEIGHT];
  logic [WIDTH-1:0]  rows_d [HEIGHT];
  upd_t              upd_q;
  upd_t              upd_d;

  logic [RW-1:0]     row_idx;
  logic [CW-1:0]     col_idx;
  logic              row_ok;
  logic              col_ok;
  logic [WIDTH-1:0]  rect_mask;
  logic [HEIGHT-1:0] col_vec;
  logic [WIDTH-1:0]  rstage [ARG_W+1];
  logic [HEIGHT-1:0] cstage [ARG_W+1];

  // index decode and range checks
  assign row_idx = cmd_i.arg_a[RW-1:0];
  assign col_idx = cmd_i.arg_a[CW-1:0];
  assign row_ok  = cmd_i.arg_a < ARG_W'(HEIGHT);
  assign col_ok  = cmd_i.arg_a < ARG_W'(WIDTH);

  // columns lit by a rect fill
  always_comb begin
    for (int j = 0; j < WIDTH; j++) begin
      rect_mask[j] = ARG_W'(j) < cmd_i.arg_a;
    end
  end

  // selected column as a vector over rows
  always_comb begin
    for (int r = 0; r < HEIGHT; r++) begin
      col_vec[r] = rows_q[r][col_idx];
    end
  end

  // barrel rotators, each stage moves by its weight modulo the length
  assign rstage[0] = rows_q[row_idx];
  assign cstage[0] = col_vec;

  for (genvar k = 0; k < ARG_W; k++) begin : g_rot
    localparam int RS = (2 ** k) % WIDTH;
    localparam int CS = (2 ** k) % HEIGHT;
    if (RS == 0) begin : g_row_keep
      assign rstage[k+1] = rstage[k];
    end else begin : g_row_turn
      assign rstage[k+1] = cmd_i.arg_b[k] ?
          {rstage[k][WIDTH-1-RS:0], rstage[k][WIDTH-1:WIDTH-RS]} : rstage[k];
    end
    if (CS == 0) begin : g_col_keep
      assign cstage[k+1] = cstage[k];
    end else begin : g_col_turn
      assign cstage[k+1] = cmd_i.arg_b[k] ?
          {cstage[k][HEIGHT-1-CS:0], cstage[k][HEIGHT-1:HEIGHT-CS]} : cstage[k];
    end
  end

  // next grid
  always_comb begin
    rows_d    = rows_q;
    upd_d.valid = cmd_valid_i;
    upd_d.bad = 1'b0;
    if (cmd_valid_i) begin
      unique case (cmd_i.kind)
        KIND_RECT: begin
          for (int r = 0; r < HEIGHT; r++) begin
            if (ARG_W'(r) < cmd_i.arg_b) begin
              rows_d[r] = rows_q[r] | rect_mask;
            end
          end
        end
        KIND_ROW: begin
          if (row_ok) begin
            rows_d[row_idx] = rstage[ARG_W];
          end else begin
            upd_d.bad = 1'b1;
          end
        end
        KIND_COL: begin
          if (col_ok) begin
            for (int r = 0; r < HEIGHT; r++) begin
              rows_d[r][col_idx] = cstage[ARG_W][r];
            end
          end else begin
            upd_d.bad = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // grid and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < HEIGHT; r++) begin
        rows_q[r] <= '0;
      end
      upd_q <= '0;
    end else begin
      rows_q <= rows_d;
      upd_q  <= upd_d;
    end
  end

  assign rows_o = rows_q;
  assign upd_o  = upd_q;

`ifndef SYNTHESIS
  // error flag only follows a rotate command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_q.bad |-> $past(cmd_valid_i) &&
      ($past(cmd_i.kind) == KIND_ROW || $past(cmd_i.kind) == KIND_COL))
    else $error("bad index flag without a rotate command");

  // a rect fill never darkens a pixel of the top row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_valid_i) && $past(cmd_i.kind) == KIND_RECT |->
      (rows_q[0] & $past(rows_q[0])) == $past(rows_q[0]))
    else $error("rect fill cleared a pixel");
`endif

endmodule

FILE: rtl/brre_count.sv
module brre_count import brre_pkg::*; #(
  parameter int WIDTH  = WIDTH_DEF,
  parameter int HEIGHT = HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] rows_i [HEIGHT],
  input  upd_t             upd_i,
  output logic             done_o,
  output logic [LIT_W-1:0] lit_count_o,
  output logic             bad_index_o
);

  localparam int PW = $clog2(WIDTH + 1);
  localparam int TW = $clog2(WIDTH * HEIGHT + 1);
  localparam int SW = (TW > LIT_W) ? TW : LIT_W;

  logic [PW-1:0]    rcnt_q [HEIGHT];
  upd_t             mid_q;
  logic [SW-1:0]    sum;
  logic [LIT_W-1:0] lit_d;
  logic [LIT_W-1:0] lit_q;
  upd_t             out_q;

  function automatic logic [PW-1:0] row_pop(input logic [WIDTH-1:0] v);
    logic [PW-1:0] acc;
    acc = '0;
    for (int j = 0; j < WIDTH; j++) begin
      acc = acc + PW'(v[j]);
    end
    return acc;
  endfunction

  // first stage: lit pixels per row
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < HEIGHT; r++) begin
      rcnt_q[r] <= row_pop(rows_i[r]);
    end
  end

  // second stage: sum of rows, saturated to the field range
  always_comb begin
    sum = '0;
    for (int r = 0; r < HEIGHT; r++) begin
      sum = sum + SW'(rcnt_q[r]);
    end
    lit_d = (sum > SW'(LIT_MAX)) ? LIT_W'(LIT_MAX) : sum[LIT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    lit_q <= lit_d;
  end

  // result strobe and error flag travel with the counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      out_q <= '0;
    end else begin
      mid_q <= upd_i;
      out_q <= mid_q;
    end
  end

  assign done_o      = out_q.valid;
  assign lit_count_o = lit_q;
  assign bad_index_o = out_q.bad;

`ifndef SYNTHESIS
  // a result follows its grid update through the mid and out status registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(upd_i.valid, 2))
    else $error("result strobe without a grid update");

  // the error flag is only shown with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_index_o |-> done_o)
    else $error("error flag outside a result");
`endif

endmodule

FILE: tb/bitmap_rect_rotate_engine_unit_tb.sv
module bitmap_rect_rotate_engine_unit_tb;
  import brre_pkg::*;

  localparam int GRID_W = WIDTH_DEF;
  localparam int GRID_H = HEIGHT_DEF;
  // fourth kind code, not in the package enum; leaves the grid alone
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DEPTH  = 3;

  // one predicted result
  typedef struct packed {
    logic [LIT_W-1:0] lit;
    logic             bad;
  } lit_report_t;

  // one row of the directed command list
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ARG_W-1:0]  a;
    logic [ARG_W-1:0]  b;
    logic              typed;
    logic [LIT_W-1:0]  lit;
    logic              bad;
  } cmd_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cmd_start;
  logic              dut_busy;
  logic [KIND_W-1:0] cmd_kind;
  logic [ARG_W-1:0]  cmd_a;
  logic [ARG_W-1:0]  cmd_b;
  logic              res_done;
  logic [LIT_W-1:0]  res_lit;
  logic              res_bad;

  // typed expectation riding along with the command on the bus
  logic              cmd_typed;
  logic [LIT_W-1:0]  cmd_lit_exp;
  logic              cmd_bad_exp;

  logic [GRID_W-1:0] pixel_grid [GRID_H];
  lit_report_t       lit_report_q [$];
  cmd_row_t          plan_q [$];

  int err_count;
  int cycle_count;
  int issued_count;
  int checked_count;
  int bad_seen_count;
  int full_seen_count;

  bitmap_rect_rotate_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (cmd_start),
    .busy        (dut_busy),
    .kind_i      (cmd_kind),
    .arg_a_i     (cmd_a),
    .arg_b_i     (cmd_b),
    .done_o      (res_done),
    .lit_count_o (res_lit),
    .bad_index_o (res_bad)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // append a predicted result to the pending list
  function automatic void report_add(lit_report_t rep);
    lit_report_q.insert(lit_report_q.size(), rep);
  endfunction

  // append a row to the directed list
  function automatic void plan_add(cmd_row_t row);
    plan_q.insert(plan_q.size(), row);
  endfunction

  // grid update and lit count for one command
  function automatic lit_report_t grid_apply(logic [KIND_W-1:0] kind,
                                             logic [ARG_W-1:0] a,
                                             logic [ARG_W-1:0] b);
    int cols;
    int rows;
    int d;
    int total;
    logic [GRID_W-1:0] mask;
    logic [GRID_W-1:0] v;
    logic col_bits [GRID_H];
    lit_report_t rep;
    rep.bad = 1'b0;
    if (kind == KIND_RECT) begin
      cols = (int'(a) > GRID_W) ? GRID_W : int'(a);
      rows = (int'(b) > GRID_H) ? GRID_H : int'(b);
      mask = '0;
      for (int c = 0; c < cols; c++) mask[c] = 1'b1;
      for (int r = 0; r < rows; r++) pixel_grid[r] = pixel_grid[r] | mask;
    end else if (kind == KIND_ROW) begin
      if (int'(a) < GRID_H) begin
        d = int'(b) % GRID_W;
        if (d != 0) begin
          v = pixel_grid[a];
          pixel_grid[a] = (v << d) | (v >> (GRID_W - d));
        end
      end else begin
        rep.bad = 1'b1;
      end
    end else if (kind == KIND_COL) begin
      if (int'(a) < GRID_W) begin
        d = int'(b) % GRID_H;
        if (d != 0) begin
          for (int r = 0; r < GRID_H; r++) col_bits[r] = pixel_grid[r][a];
          for (int r = 0; r < GRID_H; r++)
            pixel_grid[r][a] = col_bits[(r + GRID_H - d) % GRID_H];
        end
      end else begin
        rep.bad = 1'b1;
      end
    end
    total = 0;
    for (int r = 0; r < GRID_H; r++) total += $countones(pixel_grid[r]);
    rep.lit = (total > LIT_MAX) ? LIT_W'(LIT_MAX) : LIT_W'(total);
    return rep;
  endfunction

  // result check first, then record the command taken at this edge
  always @(posedge clk_i) begin : result_check
    lit_report_t want;
    lit_report_t pred;
    if (rst_ni) begin
      if (res_done) begin
        if (lit_report_q.size() == 0) begin
          $error("result with no command pending: lit_count %0d bad_index %0d",
                 res_lit, res_bad);
          err_count++;
        end else begin
          want = lit_report_q.pop_front();
          checked_count++;
          if (res_lit !== want.lit) begin
            $error("lit_count: expected %0d, got %0d", want.lit, res_lit);
            err_count++;
          end
          if (res_bad !== want.bad) begin
            $error("bad_index: expected %0d, got %0d", want.bad, res_bad);
            err_count++;
          end
          if (want.bad) bad_seen_count++;
          if (want.lit == LIT_W'(GRID_W * GRID_H)) full_seen_count++;
        end
      end
      if (cmd_start && !dut_busy) begin
        pred = grid_apply(cmd_kind, cmd_a, cmd_b);
        if (cmd_typed) begin
          pred.lit = cmd_lit_exp;
          pred.bad = cmd_bad_exp;
        end
        report_add(pred);
        issued_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic cmd_row_t mk_row(logic [KIND_W-1:0] kind, int a, int b,
                                      logic typed, int lit, logic bad);
    cmd_row_t row;
    row.kind  = kind;
    row.a     = ARG_W'(a);
    row.b     = ARG_W'(b);
    row.typed = typed;
    row.lit   = LIT_W'(lit);
    row.bad   = bad;
    return row;
  endfunction

  // random command, mostly in-range rotates with a sprinkle of small rects
  function automatic cmd_row_t rand_cmd();
    int p;
    p = $urandom_range(99);
    if (p < 5)
      return mk_row(KIND_RECT, $urandom_range(0, 5), $urandom_range(0, 2), 1'b0, 0, 1'b0);
    else if (p < 7) begin
      if ($urandom_range(1))
        return mk_row(KIND_RECT, $urandom_range(64, 127), 0, 1'b0, 0, 1'b0);
      else
        return mk_row(KIND_RECT, 0, $urandom_range(0, 127), 1'b0, 0, 1'b0);
    end else if (p < 9)
      return mk_row(KIND_SPARE, $urandom_range(0, 127), $urandom_range(0, 127), 1'b0, 0, 1'b0);
    else if (p < 14)
      return mk_row(KIND_ROW, $urandom_range(GRID_H, 127), $urandom_range(0, 127),
                    1'b0, 0, 1'b0);
    else if (p < 18)
      return mk_row(KIND_COL, $urandom_range(GRID_W, 127), $urandom_range(0, 127),
                    1'b0, 0, 1'b0);
    else if (p < 59)
      return mk_row(KIND_ROW, $urandom_range(0, GRID_H - 1), $urandom_range(0, 127),
                    1'b0, 0, 1'b0);
    else
      return mk_row(KIND_COL, $urandom_range(0, GRID_W - 1), $urandom_range(0, 127),
                    1'b0, 0, 1'b0);
  endfunction

  function automatic int pick_gap(bit allow);
    if (!allow || $urandom_range(9) < 7) return 0;
    return $urandom_range(1, 8);
  endfunction

  // drive one command from the falling edge and hold it until the transfer
  task automatic send_cmd(cmd_row_t row, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_start = 1'b0;
      cmd_kind  = KIND_W'($urandom);
      cmd_a     = ARG_W'($urandom);
      cmd_b     = ARG_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_start   = 1'b1;
    cmd_kind    = row.kind;
    cmd_a       = row.a;
    cmd_b       = row.b;
    cmd_typed   = row.typed;
    cmd_lit_exp = row.lit;
    cmd_bad_exp = row.bad;
    forever begin
      @(posedge clk_i);
      if (!dut_busy) break;
    end
  endtask

  // stop sending and let every pending result come back
  task automatic drain();
    @(negedge clk_i);
    cmd_start = 1'b0;
    cmd_typed = 1'b0;
    while (lit_report_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    err_count       = 0;
    cycle_count     = 0;
    issued_count    = 0;
    checked_count   = 0;
    bad_seen_count  = 0;
    full_seen_count = 0;
    for (int r = 0; r < GRID_H; r++) pixel_grid[r] = '0;
    rst_ni      = 1'b0;
    cmd_start   = 1'b0;
    cmd_kind    = '0;
    cmd_a       = '0;
    cmd_b       = '0;
    cmd_typed   = 1'b0;
    cmd_lit_exp = '0;
    cmd_bad_exp = 1'b0;

    // directed list: empty grid first, then a few pixels pushed around
    plan_add(mk_row(KIND_ROW,   0,   5,   1'b1, 0, 1'b0));
    plan_add(mk_row(KIND_COL,   0,   3,   1'b1, 0, 1'b0));
    plan_add(mk_row(KIND_RECT,  0,   127, 1'b1, 0, 1'b0));
    plan_add(mk_row(KIND_RECT,  127, 0,   1'b1, 0, 1'b0));
    plan_add(mk_row(KIND_ROW,   8,   1,   1'b1, 0, 1'b1));
    plan_add(mk_row(KIND_ROW,   127, 127, 1'b1, 0, 1'b1));
    plan_add(mk_row(KIND_COL,   64,  1,   1'b1, 0, 1'b1));
    plan_add(mk_row(KIND_COL,   127, 0,   1'b1, 0, 1'b1));
    plan_add(mk_row(KIND_SPARE, 127, 127, 1'b1, 0, 1'b0));
    plan_add(mk_row(KIND_RECT,  1,   1,   1'b1, 1, 1'b0));
    // shifts of a whole row or column length, and zero
    plan_add(mk_row(KIND_ROW,   0,   64,  1'b1, 1, 1'b0));
    plan_add(mk_row(KIND_COL,   0,   8,   1'b1, 1, 1'b0));
    plan_add(mk_row(KIND_COL,   0,   0,   1'b1, 1, 1'b0));
    plan_add(mk_row(KIND_ROW,   0,   127, 1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_COL,   63,  127, 1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_ROW,   7,   1,   1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_RECT,  3,   2,   1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_COL,   1,   1,   1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_ROW,   7,   63,  1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_COL,   63,  9,   1'b0, 0, 1'b0));
    // oversized rects clamp to the grid
    plan_add(mk_row(KIND_RECT,  127, 1,   1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_RECT,  1,   127, 1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_ROW,   1,   0,   1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_SPARE, 0,   0,   1'b0, 0, 1'b0));
    plan_add(mk_row(KIND_ROW,   3,   65,  1'b0, 0, 1'b0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan_q[i]) send_cmd(plan_q[i], pick_gap(1'b1));
    drain();

    // random traffic with sender gaps, a full drain in the middle
    repeat (200) send_cmd(rand_cmd(), pick_gap(1'b1));
    drain();
    repeat (200) send_cmd(rand_cmd(), pick_gap(1'b1));

    // back-to-back tail, ending on a full grid
    repeat (45) send_cmd(rand_cmd(), 0);
    send_cmd(mk_row(KIND_RECT,  GRID_W, GRID_H, 1'b0, 0, 1'b0), 0);
    send_cmd(mk_row(KIND_RECT,  127,    127,    1'b0, 0, 1'b0), 0);
    send_cmd(mk_row(KIND_ROW,   7,      5,      1'b0, 0, 1'b0), 0);
    send_cmd(mk_row(KIND_COL,   63,     3,      1'b0, 0, 1'b0), 0);
    send_cmd(mk_row(KIND_SPARE, 64,     64,     1'b0, 0, 1'b0), 0);
    drain();

    $display("%0d commands sent, %0d results checked", issued_count, checked_count);
    $display("%0d out-of-grid rotates, %0d results on a full grid",
             bad_seen_count, full_seen_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
